>>> hdl/cct_pkg.sv
// Shared constants and widths for the circle collision test block.
package cct_pkg;

  // Field formats
  localparam int COORD_BITS     = 24;  // signed Q15.8 coordinates
  localparam int TRIG_FRAC_BITS = 14;  // fraction bits of cos/sin
  localparam int TRIG_BITS      = 16;
  localparam int RAD_BITS       = 20;  // unsigned Q12.8 radius
  localparam int EXT_BITS       = 21;  // unsigned Q13.8 box extent

  // Datapath widths
  localparam int DIFF_W   = COORD_BITS + 1;            // signed centre offset
  localparam int MAG_W    = DIFF_W;                    // |offset|
  localparam int PROD_W   = DIFF_W + TRIG_BITS;        // offset * trig
  localparam int SUM_W    = PROD_W + 1;                // rotated sum
  localparam int ROUND_W  = SUM_W + 2 - TRIG_FRAC_BITS; // rotated magnitude at Q.9
  localparam int RS_W     = RAD_BITS + 1;              // summed radii / doubled radius
  localparam int LIM_W    = ((EXT_BITS > RS_W) ? EXT_BITS : RS_W) + 1; // extent + radius
  localparam int SQ_W     = RS_W;                      // square operand width
  localparam int SQP_W    = 2 * SQ_W;                  // square width
  localparam int SQS_W    = SQP_W + 1;                 // sum of two squares
  localparam int CCMP_W   = (MAG_W > RS_W) ? MAG_W : RS_W;
  localparam int BCMP_W   = (ROUND_W > LIM_W) ? ROUND_W : LIM_W;

  // Stream widths
  localparam int IN_BITS    = 4 * COORD_BITS + RAD_BITS + 2 * TRIG_BITS + 2 * EXT_BITS;
  localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W  = 8;

  // Configuration port
  localparam int                    CFG_ADDR_W   = 3;
  localparam int                    CFG_DATA_W   = 32;
  localparam logic                  REG_RADIUS   = 1'b0;  // paddr[2] of circle_radius
  localparam logic [RAD_BITS-1:0]   RADIUS_RESET = RAD_BITS'(2560);

  // Operation codes
  typedef enum logic {
    OP_CIRCLE = 1'b0,
    OP_BOX    = 1'b1
  } op_t;

endpackage

>>> hdl/cct_cfg_regs.sv
// APB-style register file holding the circle radius.
module cct_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cct_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [cct_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [cct_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  output logic [cct_pkg::RAD_BITS-1:0]      circle_radius
);
  import cct_pkg::*;

  logic wr_en;
  logic sel_radius;

  assign pready     = 1'b1;
  assign sel_radius = (paddr[2] == REG_RADIUS);
  assign wr_en      = psel & penable & pwrite & pready & sel_radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      circle_radius <= RADIUS_RESET;
    end else if (wr_en) begin
      circle_radius <= pwdata[RAD_BITS-1:0];
    end
  end

  assign prdata = sel_radius ? CFG_DATA_W'(circle_radius) : '0;

endmodule

>>> hdl/circle_collision_test.sv
// Top level: pipelined circle-vs-circle / circle-vs-oriented-box overlap test.
// Throughput: one beat per cycle; each stage holds when its successor is full
//   and stalled, so bubbles are squeezed out and no beat is lost or repeated.
// Timing set by the 25x16 rotation multipliers and the 21x21 square units.
// Reset (rst, synchronous): pipeline emptied, circle_radius back to 10.0.
module circle_collision_test (
  input  logic                              clk,
  input  logic                              rst,
  // input stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // s_tdata fields, low bit up: circle_x[24], circle_y[24], target_x[24],
  // target_y[24], target_radius[20], box_cos[16], box_sin[16],
  // box_width[21], box_height[21], zero fill
  input  logic [cct_pkg::S_TDATA_W-1:0]     s_tdata,
  input  logic                              s_tuser,   // operation
  // result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [cct_pkg::M_TDATA_W-1:0]     m_tdata,   // hit, zero fill
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cct_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [cct_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [cct_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import cct_pkg::*;

  // Bit offsets of the fields in s_tdata
  localparam int CX_LO = 0;
  localparam int CY_LO = CX_LO + COORD_BITS;
  localparam int TX_LO = CY_LO + COORD_BITS;
  localparam int TY_LO = TX_LO + COORD_BITS;
  localparam int TR_LO = TY_LO + COORD_BITS;
  localparam int BC_LO = TR_LO + RAD_BITS;
  localparam int BS_LO = BC_LO + TRIG_BITS;
  localparam int BW_LO = BS_LO + TRIG_BITS;
  localparam int BH_LO = BW_LO + EXT_BITS;

  localparam logic [SUM_W:0] ROUND_HALF = (SUM_W + 1)'(1) << (TRIG_FRAC_BITS - 2);

  logic [RAD_BITS-1:0] circle_radius;

  cct_cfg_regs u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .circle_radius (circle_radius)
  );

  // ---------------------------------------------------------------------
  // Stage handshake: a stage loads when it is empty or its successor loads.
  // ---------------------------------------------------------------------
  logic v1, v2, v3, v4, v5, vout;
  logic en1, en2, en3, en4, en5, en6;

  assign en6      = ~vout | m_tready;
  assign en5      = ~v5 | en6;
  assign en4      = ~v4 | en5;
  assign en3      = ~v3 | en4;
  assign en2      = ~v2 | en3;
  assign en1      = ~v1 | en2;
  assign s_tready = en1;
  assign m_tvalid = vout;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      v4   <= 1'b0;
      v5   <= 1'b0;
      vout <= 1'b0;
    end else begin
      if (en1) v1   <= s_tvalid;
      if (en2) v2   <= v1;
      if (en3) v3   <= v2;
      if (en4) v4   <= v3;
      if (en5) v5   <= v4;
      if (en6) vout <= v5;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: centre offsets, summed and doubled radius.
  // ---------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] in_cx, in_cy, in_tx, in_ty;
  logic        [RAD_BITS-1:0]   in_tr;

  assign in_cx = s_tdata[CX_LO +: COORD_BITS];
  assign in_cy = s_tdata[CY_LO +: COORD_BITS];
  assign in_tx = s_tdata[TX_LO +: COORD_BITS];
  assign in_ty = s_tdata[TY_LO +: COORD_BITS];
  assign in_tr = s_tdata[TR_LO +: RAD_BITS];

  op_t                        op1;
  logic signed [DIFF_W-1:0]   dx1, dy1;
  logic signed [TRIG_BITS-1:0] c1, s1;
  logic        [EXT_BITS-1:0] w1, h1;
  logic        [RS_W-1:0]     rs1, r1;

  always_ff @(posedge clk) begin
    if (en1) begin
      op1 <= op_t'(s_tuser);
      dx1 <= DIFF_W'(in_tx) - DIFF_W'(in_cx);
      dy1 <= DIFF_W'(in_ty) - DIFF_W'(in_cy);
      c1  <= s_tdata[BC_LO +: TRIG_BITS];
      s1  <= s_tdata[BS_LO +: TRIG_BITS];
      w1  <= s_tdata[BW_LO +: EXT_BITS];
      h1  <= s_tdata[BH_LO +: EXT_BITS];
      rs1 <= RS_W'(circle_radius) + RS_W'(in_tr);
      r1  <= {circle_radius, 1'b0};   // radius at Q.9
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: rotation products and offset magnitudes.
  // ---------------------------------------------------------------------
  op_t                       op2;
  logic signed [PROD_W-1:0]  pdxc, pdys, pdyc, pdxs;
  logic        [MAG_W-1:0]   ax2, ay2;
  logic        [EXT_BITS-1:0] w2, h2;
  logic        [RS_W-1:0]    rs2, r2;

  always_ff @(posedge clk) begin
    if (en2) begin
      op2  <= op1;
      pdxc <= PROD_W'(dx1) * PROD_W'(c1);
      pdys <= PROD_W'(dy1) * PROD_W'(s1);
      pdyc <= PROD_W'(dy1) * PROD_W'(c1);
      pdxs <= PROD_W'(dx1) * PROD_W'(s1);
      ax2  <= MAG_W'(dx1[DIFF_W-1] ? -dx1 : dx1);
      ay2  <= MAG_W'(dy1[DIFF_W-1] ? -dy1 : dy1);
      w2   <= w1;
      h2   <= h1;
      rs2  <= rs1;
      r2   <= r1;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: rotated sums rounded to Q.9 magnitudes; circle far check.
  // lx = dx*cos - dy*sin, ly = dy*cos + dx*sin
  // ---------------------------------------------------------------------
  logic signed [SUM_W-1:0] sum_a, sum_b;
  logic        [SUM_W:0]   rnd_a, rnd_b;
  logic                    cfar;

  assign sum_a = SUM_W'(pdxc) - SUM_W'(pdys);
  assign sum_b = SUM_W'(pdyc) + SUM_W'(pdxs);
  // round half away from zero on the magnitude
  assign rnd_a = {1'b0, (sum_a[SUM_W-1] ? -sum_a : sum_a)} + ROUND_HALF;
  assign rnd_b = {1'b0, (sum_b[SUM_W-1] ? -sum_b : sum_b)} + ROUND_HALF;
  assign cfar  = (CCMP_W'(ax2) > CCMP_W'(rs2)) | (CCMP_W'(ay2) > CCMP_W'(rs2));

  op_t                    op3;
  logic [ROUND_W-1:0]     a3, b3;
  logic                   cfar3;
  logic [SQ_W-1:0]        ax3, ay3;
  logic [EXT_BITS-1:0]    w3, h3;
  logic [RS_W-1:0]        rs3, r3;

  always_ff @(posedge clk) begin
    if (en3) begin
      op3   <= op2;
      a3    <= rnd_a[SUM_W:TRIG_FRAC_BITS-1];
      b3    <= rnd_b[SUM_W:TRIG_FRAC_BITS-1];
      cfar3 <= cfar;
      ax3   <= SQ_W'(ax2);   // only used when not far, then fits
      ay3   <= SQ_W'(ay2);
      w3    <= w2;
      h3    <= h2;
      rs3   <= rs2;
      r3    <= r2;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: box range checks, early decisions, square operand select.
  // ---------------------------------------------------------------------
  logic [LIM_W-1:0]  wr, hr;
  logic [BCMP_W-1:0] ex_full, ey_full;
  logic              bfar, binside;
  logic              dec_d, ehit_d;
  logic [SQ_W-1:0]   u_d, v_d, lim_d;

  assign wr      = LIM_W'(w3) + LIM_W'(r3);
  assign hr      = LIM_W'(h3) + LIM_W'(r3);
  assign bfar    = (BCMP_W'(a3) > BCMP_W'(wr)) | (BCMP_W'(b3) > BCMP_W'(hr));
  assign binside = (BCMP_W'(a3) <= BCMP_W'(w3)) | (BCMP_W'(b3) <= BCMP_W'(h3));
  // corner offsets: bounded by the doubled radius once not far
  assign ex_full = BCMP_W'(a3) - BCMP_W'(w3);
  assign ey_full = BCMP_W'(b3) - BCMP_W'(h3);

  always_comb begin
    case (op3)
      OP_CIRCLE: begin
        dec_d  = cfar3;
        ehit_d = 1'b0;
        u_d    = ax3;
        v_d    = ay3;
        lim_d  = SQ_W'(rs3);
      end
      OP_BOX: begin
        dec_d  = bfar | binside;
        ehit_d = ~bfar & binside;
        u_d    = SQ_W'(ex_full);
        v_d    = SQ_W'(ey_full);
        lim_d  = SQ_W'(r3);
      end
      default: begin
        dec_d  = 1'b1;
        ehit_d = 1'b0;
        u_d    = '0;
        v_d    = '0;
        lim_d  = '0;
      end
    endcase
  end

  logic            dec4, ehit4;
  logic [SQ_W-1:0] u4, w4v, lim4;

  always_ff @(posedge clk) begin
    if (en4) begin
      dec4  <= dec_d;
      ehit4 <= ehit_d;
      u4    <= u_d;
      w4v   <= v_d;
      lim4  <= lim_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: squares.
  // ---------------------------------------------------------------------
  logic             dec5, ehit5;
  logic [SQP_W-1:0] usq5, vsq5, limsq5;

  always_ff @(posedge clk) begin
    if (en5) begin
      dec5   <= dec4;
      ehit5  <= ehit4;
      usq5   <= SQP_W'(u4) * SQP_W'(u4);
      vsq5   <= SQP_W'(w4v) * SQP_W'(w4v);
      limsq5 <= SQP_W'(lim4) * SQP_W'(lim4);
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: distance compare, output register.
  // ---------------------------------------------------------------------
  logic [SQS_W-1:0] dist_sq;
  logic             hit_d;
  logic             hit_q;

  assign dist_sq = SQS_W'(usq5) + SQS_W'(vsq5);
  assign hit_d   = dec5 ? ehit5 : (dist_sq <= SQS_W'(limsq5));

  always_ff @(posedge clk) begin
    if (en6) begin
      hit_q <= hit_d;
    end
  end

  assign m_tdata = {{(M_TDATA_W - 1){1'b0}}, hit_q};

endmodule

>>> hdl/cct_checker.sv
// Port-level checker for the circle collision test, bound to the top level.
module cct_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [cct_pkg::M_TDATA_W-1:0]     m_tdata,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic [cct_pkg::CFG_ADDR_W-1:0]    paddr,
  input logic [cct_pkg::CFG_DATA_W-1:0]    pwdata,
  input logic [cct_pkg::CFG_DATA_W-1:0]    prdata
);
  import cct_pkg::*;

  // a held result beat keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  // reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // with nothing waiting at the output the pipeline always takes a beat
  a_no_block: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input blocked with empty output");

  // only the hit bit may be set
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[M_TDATA_W-1:1] == '0))
    else $error("padding bits of result set");

  // radius reads back what was written
  a_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && (paddr[2] == REG_RADIUS)
    |=> (paddr[2] != REG_RADIUS) || (prdata[RAD_BITS-1:0] == $past(pwdata[RAD_BITS-1:0])))
    else $error("radius readback mismatch");

endmodule

bind circle_collision_test cct_checker u_cct_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata)
);

>>> bench/tb_top.sv
// Self-checking testbench for circle_collision_test: directed table plus random pairs.
`timescale 1ns / 1ps

module tb_top;
  import cct_pkg::*;

  // Drain wait used when letting the block settle, with margin beyond the pipeline depth.
  localparam int PIPE_DEPTH   = 8;
  // Long receiver hold-off used to back the pipeline up into the input side.
  localparam int HOLD_CYCLES  = 400;
  // Cycles without any beat before the run is declared hung.
  localparam int QUIET_LIMIT  = 4000;
  localparam int PAIRS_PER_PHASE = 120;
  localparam int N_DIRECTED   = 22;
  localparam logic [CFG_ADDR_W-1:0] RADIUS_ADDR = CFG_ADDR_W'({REG_RADIUS, 2'b00});
  // Half of one Q.9 step at the rotated-product scale, for round half away from zero.
  localparam longint HALF_Q9 = longint'(1) << (TRIG_FRAC_BITS - 2);

  // How the expected hit of a directed row is obtained.
  typedef enum logic [1:0] {
    PIN_PREDICT,
    PIN_MISS,
    PIN_HIT
  } pin_t;

  // Input beat as it sits on s_tdata; first member is the top bits.
  typedef struct packed {
    logic [S_TDATA_W-IN_BITS-1:0]  fill;
    logic [EXT_BITS-1:0]           box_height;
    logic [EXT_BITS-1:0]           box_width;
    logic signed [TRIG_BITS-1:0]   box_sin;
    logic signed [TRIG_BITS-1:0]   box_cos;
    logic [RAD_BITS-1:0]           target_radius;
    logic signed [COORD_BITS-1:0]  target_y;
    logic signed [COORD_BITS-1:0]  target_x;
    logic signed [COORD_BITS-1:0]  circle_y;
    logic signed [COORD_BITS-1:0]  circle_x;
  } pair_beat_t;

  // One row of the directed table.
  typedef struct packed {
    int op;
    int cx;
    int cy;
    int tx;
    int ty;
    int tr;
    int cs;
    int sn;
    int w;
    int h;
    int pin;
  } pair_row_t;

  // All directed rows run at the reset radius of 10.0 (2560 in Q.8).
  localparam pair_row_t DIRECTED_PAIRS [N_DIRECTED] = '{
    // circle mode: coincident, touching, just apart on each axis
    '{OP_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0, 0, PIN_HIT},
    '{OP_CIRCLE, 0, 0, 2560, 0, 0, 0, 0, 0, 0, PIN_HIT},
    '{OP_CIRCLE, 0, 0, 2561, 0, 0, 0, 0, 0, 0, PIN_MISS},
    '{OP_CIRCLE, 0, 0, 0, -2561, 0, 0, 0, 0, 0, PIN_MISS},
    '{OP_CIRCLE, 1000, -1000, 3816, -1000, 256, 0, 0, 0, 0, PIN_HIT},
    // coordinate and radius extremes
    '{OP_CIRCLE, -8388608, -8388608, 8388607, 8388607, 1048575, 0, 0, 0, 0, PIN_MISS},
    '{OP_CIRCLE, 8388607, -8388608, 8388607, -8388608, 1048575, 0, 0, 0, 0, PIN_HIT},
    // diagonal, on either side of the summed radius
    '{OP_CIRCLE, 0, 0, 1810, 1810, 0, 0, 0, 0, 0, PIN_PREDICT},
    '{OP_CIRCLE, 0, 0, -1811, 1811, 0, 0, 0, 0, 0, PIN_PREDICT},
    // box fields are don't-care in circle mode
    '{OP_CIRCLE, 0, 0, 100, 0, 0, 32767, -32768, 2097151, 2097151, PIN_HIT},
    // box mode: zero extents, target radius ignored
    '{OP_BOX, 0, 0, 0, 0, 1048575, 16384, 0, 0, 0, PIN_HIT},
    // axis aligned, offset exactly at half width plus radius, then one past
    '{OP_BOX, 0, 0, 3584, 0, 0, 16384, 0, 2048, 2048, PIN_HIT},
    '{OP_BOX, 0, 0, 3585, 0, 0, 16384, 0, 2048, 2048, PIN_MISS},
    '{OP_BOX, 0, 0, -3584, 0, 0, 16384, 0, 2048, 2048, PIN_HIT},
    // corner region, inside and just outside the rounded corner
    '{OP_BOX, 0, 0, 2834, 2834, 0, 16384, 0, 2048, 2048, PIN_PREDICT},
    '{OP_BOX, 0, 0, 2836, -2836, 0, 16384, 0, 2048, 2048, PIN_PREDICT},
    // quarter turn, then trig beyond unit magnitude
    '{OP_BOX, 0, 0, 4000, 0, 0, 0, 16384, 0, 8192, PIN_PREDICT},
    '{OP_BOX, 500, 500, 1500, -700, 0, -16384, -16384, 3000, 1000, PIN_PREDICT},
    '{OP_BOX, 0, 0, 100, -50, 0, 32767, -32768, 1000, 1000, PIN_PREDICT},
    // tiny trig: rotated sum sits exactly on a rounding half step
    '{OP_BOX, 0, 0, 4096, 0, 0, 1, 0, 0, 0, PIN_PREDICT},
    // extremes of coordinates, trig and extents
    '{OP_BOX, -8388608, -8388608, 8388607, 8388607, 0, -16384, 16384, 2097151, 2097151,
      PIN_PREDICT},
    '{OP_BOX, 8388607, 8388607, 8388607, 8388607, 1048575, 16384, 0, 2097151, 2097151,
      PIN_HIT}
  };

  // DUT signals; every input starts at a known value.
  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata  = '0;
  logic                   s_tuser  = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [CFG_ADDR_W-1:0]  paddr    = '0;
  logic [CFG_DATA_W-1:0]  pwdata   = '0;
  logic [CFG_DATA_W-1:0]  prdata;
  logic                   pready;

  // Bench state
  logic [RAD_BITS-1:0]    circle_radius_q8 = RADIUS_RESET;  // mirror of the radius register
  bit                     hits_due [$];                     // expected hit per accepted pair
  pin_t                   beat_pin   = PIN_PREDICT;         // travels with s_tdata
  bit                     calm       = 1'b0;                // no idling on either side
  bit                     hold_go    = 1'b0;                // request for the long hold-off
  bit                     hold_taken = 1'b0;
  int                     hold_left  = 0;
  int                     quiet      = 0;
  int                     mismatches = 0;
  bit                     due_hit;

  always #5 clk = ~clk;

  circle_collision_test i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Overlap predictor. Circle mode: exact squared distance at Q.8.
  // Box mode: rotate the offset, reduce to Q.9 magnitudes, then slab and corner tests.
  function automatic bit predict_hit(op_t op, pair_beat_t p, logic [RAD_BITS-1:0] radius);
    longint dx, dy, rad, rs, ax, ay, c, s, rot_x, rot_y, a, b, r, w, h, ex, ey;
    dx  = longint'($signed(p.target_x)) - longint'($signed(p.circle_x));
    dy  = longint'($signed(p.target_y)) - longint'($signed(p.circle_y));
    rad = longint'(radius);
    if (op == OP_CIRCLE) begin
      rs = rad + longint'(p.target_radius);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      // far on one axis: miss before any squaring
      if (ax > rs || ay > rs) return 1'b0;
      return (ax * ax + ay * ay) <= rs * rs;
    end
    c     = longint'($signed(p.box_cos));
    s     = longint'($signed(p.box_sin));
    rot_x = dx * c - dy * s;
    rot_y = dy * c + dx * s;
    a = (((rot_x < 0) ? -rot_x : rot_x) + HALF_Q9) >> (TRIG_FRAC_BITS - 1);
    b = (((rot_y < 0) ? -rot_y : rot_y) + HALF_Q9) >> (TRIG_FRAC_BITS - 1);
    // at Q.9 the full extent is the half extent and the radius doubles
    r = 2 * rad;
    w = longint'(p.box_width);
    h = longint'(p.box_height);
    if (a > w + r || b > h + r) return 1'b0;
    if (a <= w || b <= h) return 1'b1;
    ex = a - w;
    ey = b - h;
    return (ex * ex + ey * ey) <= r * r;
  endfunction

  function automatic pair_beat_t pack_pair(longint cx, longint cy, longint tx, longint ty,
                                           longint tr, longint cs, longint sn,
                                           longint w, longint h);
    pair_beat_t p;
    p               = '0;
    p.circle_x      = COORD_BITS'(cx);
    p.circle_y      = COORD_BITS'(cy);
    p.target_x      = COORD_BITS'(tx);
    p.target_y      = COORD_BITS'(ty);
    p.target_radius = RAD_BITS'(tr);
    p.box_cos       = TRIG_BITS'(cs);
    p.box_sin       = TRIG_BITS'(sn);
    p.box_width     = EXT_BITS'(w);
    p.box_height    = EXT_BITS'(h);
    return p;
  endfunction

  // Mostly small sizes so hits are common; some zero, some anywhere in range.
  function automatic longint pick_size(int bits);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) return 0;
    if (roll < 25) return longint'($urandom) & ((longint'(1) << bits) - 1);
    return longint'($urandom_range(0, 16383));
  endfunction

  // Random pair: mostly a target placed around the contact distance, some pure noise.
  function automatic pair_beat_t random_pair(output op_t op);
    longint tr, w, h, rad, reach, dx, dy, cx, cy, cs, sn;
    real ang;
    pair_beat_t p;
    op = op_t'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < 10) begin
      // noise: every bit of every field is random
      p = pair_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
      p.fill = '0;
      return p;
    end
    tr  = pick_size(RAD_BITS);
    w   = pick_size(EXT_BITS);
    h   = pick_size(EXT_BITS);
    rad = longint'(circle_radius_q8);
    if ($urandom_range(0, 99) < 20) begin
      // unnormalized trig, full 16-bit range
      cs = longint'($urandom);
      sn = longint'($urandom);
    end else begin
      ang = real'($urandom_range(0, 6283)) / 1000.0;
      cs  = longint'($rtoi(16384.0 * $cos(ang)));
      sn  = longint'($rtoi(16384.0 * $sin(ang)));
    end
    reach = (op == OP_CIRCLE) ? rad + tr : rad + (((w > h) ? w : h) >> 1);
    reach = reach + reach / 2 + 16;
    dx = longint'($urandom_range(0, 32'(2 * reach))) - reach;
    dy = longint'($urandom_range(0, 32'(2 * reach))) - reach;
    cx = longint'($urandom);
    cy = longint'($urandom);
    return pack_pair(cx, cy, cx + dx, cy + dy, tr, cs, sn, w, h);
  endfunction

  // Append one expected hit behind the ones already due.
  function automatic void add_due(input bit value);
    hits_due.insert(hits_due.size(), value);
  endfunction

  // Offer one pair, with random gaps ahead of it outside calm stretches; returns after the accepting edge.
  // s_tvalid is left high so back-to-back beats never toggle it within a step.
  task automatic offer(input op_t op, input pair_beat_t p, input pin_t pin);
    while (!calm && $urandom_range(0, 99) < 18) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= p;
    s_tuser  <= op;
    beat_pin <= pin;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop sending and wait for every expected hit, then let the pipeline drain.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (hits_due.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH) @(posedge clk);
  endtask

  // Write the radius register, then read it back through the same port.
  task automatic write_radius(input logic [RAD_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RADIUS_ADDR;
    pwdata  <= CFG_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    // back-to-back read: psel stays up, new setup cycle
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== CFG_DATA_W'(value)) begin
      $error("circle_radius: expected %0d, got %0d", value, prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random back-pressure, one long hold-off on request, calm stretches.
  always @(posedge clk) begin
    if (hold_go && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES;
      m_tready   <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (calm) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= 18);
    end
  end

  // Scoreboard: track the radius register, predict on input beats, check output beats.
  always @(posedge clk) begin
    if (rst) begin
      circle_radius_q8 <= RADIUS_RESET;
    end else begin
      if (psel && penable && pwrite && pready && paddr == RADIUS_ADDR)
        circle_radius_q8 <= pwdata[RAD_BITS-1:0];
      if (s_tvalid && s_tready) begin
        if (beat_pin == PIN_PREDICT)
          add_due(predict_hit(op_t'(s_tuser), pair_beat_t'(s_tdata), circle_radius_q8));
        else
          add_due(beat_pin == PIN_HIT);
      end
      if (m_tvalid && m_tready) begin
        if (hits_due.size() == 0) begin
          $error("hit: result beat with nothing expected, got %0b", m_tdata[0]);
          mismatches++;
        end else begin
          due_hit = hits_due.pop_front();
          if (m_tdata[0] !== due_hit) begin
            $error("hit: expected %0b, got %0b", due_hit, m_tdata[0]);
            mismatches++;
          end
        end
      end
    end
  end

  // Watchdog: any beat on either stream resets the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL circle_collision_test");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Stimulus: directed table at the reset radius, then random phases over
  // several radius settings (zero, full scale, random, tiny, default).
  initial begin
    pair_beat_t          p;
    op_t                 op;
    logic [RAD_BITS-1:0] radius;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      p = pack_pair(DIRECTED_PAIRS[i].cx, DIRECTED_PAIRS[i].cy, DIRECTED_PAIRS[i].tx,
                    DIRECTED_PAIRS[i].ty, DIRECTED_PAIRS[i].tr, DIRECTED_PAIRS[i].cs,
                    DIRECTED_PAIRS[i].sn, DIRECTED_PAIRS[i].w, DIRECTED_PAIRS[i].h);
      offer(op_t'(DIRECTED_PAIRS[i].op), p, pin_t'(DIRECTED_PAIRS[i].pin));
    end
    settle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: radius = '0;
        1: radius = '1;
        2: radius = RAD_BITS'($urandom_range(1, (1 << RAD_BITS) - 2));
        3: radius = RAD_BITS'(1);
        default: radius = RADIUS_RESET;
      endcase
      write_radius(radius);
      // tiny-radius phase runs with no idling on either side
      calm <= (ph == 3);
      for (int n = 0; n < PAIRS_PER_PHASE; n++) begin
        // receiver stalls for a long stretch while pairs keep coming
        if (ph == 1 && n == 10) hold_go <= 1'b1;
        // sender pause until every result is back
        if (ph == 2 && n == 60) settle();
        p = random_pair(op);
        offer(op, p, PIN_PREDICT);
      end
      settle();
    end

    if (mismatches == 0)
      $display("PASS circle_collision_test");
    else
      $display("FAIL circle_collision_test");
    $finish;
  end

endmodule
